// ===== rtl/core/gtd_pkg.sv =====
// shared constants, codes and control types for the goertzel tone detector
package gtd_pkg;

    localparam int STATE_BITS_DEF = 48;
    localparam int FRAC_BITS_DEF  = 14;

    localparam int OP_W       = 2;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int COEF_FRAC  = 14;
    localparam int FMT_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MAG_W      = 63;

    localparam int CHUNK_W    = 16;
    localparam int DIG_W      = CHUNK_W + 1;
    localparam int ROOT_W     = 63;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 4;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int CNT_W      = 6;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [FMT_W-1:0] {
        FMT_S16 = 2'd0,
        FMT_U8  = 2'd1,
        FMT_U16 = 2'd2
    } fmt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF   = 2'd0,
        REG_FORMAT = 2'd1,
        REG_ROOT   = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        MUL_STEP     = 3'd0,
        MUL_NEG_COEF = 3'd1,
        MUL_Q1_SCALE = 3'd2,
        MUL_R_CHUNK  = 3'd3,
        MUL_Q2_CHUNK = 3'd4
    } mul_sel_t;

    typedef struct packed {
        logic     in_load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     chunk_first;
        logic     chunk_last;
        logic     acc_en;
        logic     acc_clr;
        logic     split_load;
        logic     update_en;
        logic     state_clr;
        logic     sqrt_init;
        logic     sqrt_step;
        logic     out_load;
    } gtd_cmd_t;

    typedef struct packed {
        logic root_mode;
    } gtd_status_t;

endpackage

// ===== rtl/core/gtd_if.sv =====
// valid/ready channel interfaces for items, results and register writes
interface gtd_in_if;
    import gtd_pkg::*;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output op, output sample, input ready);
    modport sink   (input valid, input op, input sample, output ready);
endinterface

interface gtd_out_if;
    import gtd_pkg::*;
    logic             valid;
    logic             ready;
    logic [MAG_W-1:0] magnitude;
    logic             saturated;

    modport source (output valid, output magnitude, output saturated, input ready);
    modport sink   (input valid, input magnitude, input saturated, output ready);
endinterface

interface gtd_cfg_if;
    import gtd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/gtd_ctrl.sv =====
// controller state machine sequencing sample updates, reads and root extraction
module gtd_ctrl #(
    parameter int STATE_BITS = gtd_pkg::STATE_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [gtd_pkg::OP_W-1:0]  in_op,
    output logic                      in_ready,
    output logic                      out_valid,
    input  logic                      out_ready,
    input  gtd_pkg::gtd_status_t      status,
    output gtd_pkg::gtd_cmd_t         cmd
);
    import gtd_pkg::*;

    localparam int NR    = (STATE_BITS + CHUNK_W + CHUNK_W - 1) / CHUNK_W;
    localparam int NQ    = (STATE_BITS + CHUNK_W - 1) / CHUNK_W;
    localparam int NSTEP = 2 + NR + NQ;

    localparam logic [CNT_W-1:0] STEP_NEG   = CNT_W'(0);
    localparam logic [CNT_W-1:0] STEP_SCALE = CNT_W'(1);
    localparam logic [CNT_W-1:0] STEP_R0    = CNT_W'(2);
    localparam logic [CNT_W-1:0] STEP_RN    = CNT_W'(2 + NR - 1);
    localparam logic [CNT_W-1:0] STEP_Q0    = CNT_W'(2 + NR);
    localparam logic [CNT_W-1:0] STEP_LAST  = CNT_W'(NSTEP - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST  = CNT_W'(SQRT_STEPS - 1);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_STEP_MUL = 8'b0000_0010,
        S_STEP_UPD = 8'b0000_0100,
        S_RD_MUL   = 8'b0000_1000,
        S_RD_ACC   = 8'b0001_0000,
        S_RD_FIN   = 8'b0010_0000,
        S_RD_SQRT  = 8'b0100_0000,
        S_RD_OUT   = 8'b1000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic             out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        cmd            = '0;
        cmd.mul_sel    = MUL_STEP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.in_load = 1'b1;
                    unique case (op_t'(in_op))
                        OP_SAMPLE: state_next = S_STEP_MUL;
                        OP_READ:
                        begin
                            step_next  = '0;
                            state_next = S_RD_MUL;
                        end
                        OP_CLEAR: cmd.state_clr = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_STEP_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_STEP;
                state_next  = S_STEP_UPD;
            end
            S_STEP_UPD:
            begin
                cmd.update_en = 1'b1;
                state_next    = S_IDLE;
            end
            S_RD_MUL:
            begin
                cmd.mul_en = 1'b1;
                if (step_reg == STEP_NEG)
                begin
                    cmd.mul_sel = MUL_NEG_COEF;
                end
                else if (step_reg == STEP_SCALE)
                begin
                    cmd.mul_sel = MUL_Q1_SCALE;
                end
                else if (step_reg < STEP_Q0)
                begin
                    cmd.mul_sel     = MUL_R_CHUNK;
                    cmd.chunk_first = (step_reg == STEP_R0);
                    cmd.chunk_last  = (step_reg == STEP_RN);
                end
                else
                begin
                    cmd.mul_sel     = MUL_Q2_CHUNK;
                    cmd.chunk_first = (step_reg == STEP_Q0);
                    cmd.chunk_last  = (step_reg == STEP_LAST);
                end
                state_next = S_RD_ACC;
            end
            S_RD_ACC:
            begin
                cmd.acc_en     = 1'b1;
                cmd.acc_clr    = (step_reg == STEP_NEG) || (step_reg == STEP_R0);
                cmd.split_load = (step_reg == STEP_SCALE);
                if (step_reg == STEP_LAST)
                begin
                    state_next = S_RD_FIN;
                end
                else
                begin
                    step_next  = step_reg + CNT_W'(1);
                    state_next = S_RD_MUL;
                end
            end
            S_RD_FIN:
            begin
                if (status.root_mode)
                begin
                    cmd.sqrt_init = 1'b1;
                    step_next     = '0;
                    state_next    = S_RD_SQRT;
                end
                else
                begin
                    state_next = S_RD_OUT;
                end
            end
            S_RD_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (step_reg == SQRT_LAST)
                begin
                    state_next = S_RD_OUT;
                end
                else
                begin
                    step_next = step_reg + CNT_W'(1);
                end
            end
            S_RD_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.state_clr  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/gtd_datapath.sv =====
// datapath: registers, shared digit multiplier, accumulator, saturation and square root
module gtd_datapath #(
    parameter int STATE_BITS = gtd_pkg::STATE_BITS_DEF,
    parameter int FRAC_BITS  = gtd_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  gtd_pkg::gtd_cmd_t               cmd,
    output gtd_pkg::gtd_status_t            status,
    input  logic [gtd_pkg::SAMPLE_W-1:0]    sample,
    input  logic                            cfg_write,
    input  logic [gtd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gtd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic [gtd_pkg::MAG_W-1:0]       magnitude,
    output logic                            saturated
);
    import gtd_pkg::*;

    localparam int NR     = (STATE_BITS + CHUNK_W + CHUNK_W - 1) / CHUNK_W;
    localparam int NQ     = (STATE_BITS + CHUNK_W - 1) / CHUNK_W;
    localparam int RW     = CHUNK_W * NR;
    localparam int QW     = CHUNK_W * NQ;
    localparam int PW     = STATE_BITS + DIG_W;
    localparam int ACC_W  = 2 * STATE_BITS + 18;
    localparam int SH_W   = $clog2(CHUNK_W * NR + COEF_FRAC + 1);
    localparam int SUM_A  = STATE_BITS + 3;
    localparam int SUM_B  = SAMPLE_W + FRAC_BITS;
    localparam int SUM_W  = ((SUM_A > SUM_B) ? SUM_A : SUM_B) + 2;
    localparam int SQ_SH  = 2 * FRAC_BITS + COEF_FRAC;
    localparam int MW     = ACC_W - 1 - SQ_SH;
    localparam int EXT_W  = (MW > RAD_W + 1) ? MW : RAD_W + 1;

    localparam logic signed [DIG_W-1:0] ONE_COEF = DIG_W'(1 << COEF_FRAC);
    localparam logic [SH_W-1:0]         SH_STEP  = SH_W'(CHUNK_W);
    localparam logic [SH_W-1:0]         SH_Q2    = SH_W'(COEF_FRAC);

    // configuration
    logic signed [COEF_W-1:0]     coef_reg;
    logic [FMT_W-1:0]             fmt_reg;
    logic                         root_mode_reg;

    // filter state
    logic signed [STATE_BITS-1:0] q1_reg, q2_reg;
    logic                         ovf_reg;
    logic [SAMPLE_W-1:0]          sample_reg;

    // multiply and accumulate
    logic signed [STATE_BITS-1:0] mul_a;
    logic signed [DIG_W-1:0]      mul_d;
    logic signed [DIG_W-1:0]      coef_ext;
    logic signed [PW-1:0]         prod_reg, prod_next;
    logic [SH_W-1:0]              shamt_reg;
    logic signed [ACC_W-1:0]      acc_reg, acc_next, addend;
    logic [RW-1:0]                r_sh_reg;
    logic [QW-1:0]                q_sh_reg;

    // sample update
    logic signed [SAMPLE_W-1:0]   value;
    logic signed [SUM_W-1:0]      x_ext, sum;
    logic [SUM_W-STATE_BITS:0]    sum_top;
    logic                         sum_fits;
    logic signed [STATE_BITS-1:0] sum_sat;

    // magnitude
    logic [MW-1:0]                m_u;
    logic [EXT_W-1:0]             m_ext;
    logic                         sq_sat;
    logic [MAG_W-1:0]             sq_mag;
    logic [RAD_W-1:0]             rad_in;

    // square root
    logic [RAD_W-1:0]             rad_reg;
    logic [REM_W-1:0]             rem_reg, rem_sh, trial;
    logic [ROOT_W-1:0]            sq_root_reg;
    logic                         root_ge;

    logic [MAG_W-1:0]             mag_out_reg;
    logic                         sat_out_reg;

    assign status.root_mode = root_mode_reg;
    assign magnitude        = mag_out_reg;
    assign saturated        = sat_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg      <= '0;
            fmt_reg       <= '0;
            root_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_COEF:   coef_reg      <= cfg_data[COEF_W-1:0];
                REG_FORMAT: fmt_reg       <= cfg_data[FMT_W-1:0];
                REG_ROOT:   root_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // offset removal
    always_comb
    begin
        unique case (fmt_t'(fmt_reg))
            FMT_U8:  value = {{(SAMPLE_W-8){~sample_reg[7]}}, ~sample_reg[7], sample_reg[6:0]};
            FMT_U16: value = {~sample_reg[SAMPLE_W-1], sample_reg[SAMPLE_W-2:0]};
            default: value = sample_reg;
        endcase
    end

    assign coef_ext = DIG_W'(coef_reg);

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_NEG_COEF:
            begin
                mul_a = q2_reg;
                mul_d = -coef_ext;
            end
            MUL_Q1_SCALE:
            begin
                mul_a = q1_reg;
                mul_d = ONE_COEF;
            end
            MUL_R_CHUNK:
            begin
                mul_a = q1_reg;
                mul_d = cmd.chunk_last ? {r_sh_reg[CHUNK_W-1], r_sh_reg[CHUNK_W-1:0]}
                                       : {1'b0, r_sh_reg[CHUNK_W-1:0]};
            end
            MUL_Q2_CHUNK:
            begin
                mul_a = q2_reg;
                mul_d = cmd.chunk_last ? {q_sh_reg[CHUNK_W-1], q_sh_reg[CHUNK_W-1:0]}
                                       : {1'b0, q_sh_reg[CHUNK_W-1:0]};
            end
            default:
            begin
                mul_a = q1_reg;
                mul_d = coef_ext;
            end
        endcase
    end

    assign prod_next = mul_a * mul_d;
    assign addend    = ACC_W'(prod_reg) <<< shamt_reg;
    assign acc_next  = (cmd.acc_clr ? '0 : acc_reg) + addend;

    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            sample_reg <= sample;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
            case (cmd.mul_sel)
                MUL_R_CHUNK:
                begin
                    shamt_reg <= cmd.chunk_first ? '0 : shamt_reg + SH_STEP;
                    r_sh_reg  <= r_sh_reg >> CHUNK_W;
                end
                MUL_Q2_CHUNK:
                begin
                    shamt_reg <= cmd.chunk_first ? SH_Q2 : shamt_reg + SH_STEP;
                    q_sh_reg  <= q_sh_reg >> CHUNK_W;
                end
                default: shamt_reg <= '0;
            endcase
        end
        if (cmd.acc_en)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.split_load)
        begin
            r_sh_reg <= acc_next[RW-1:0];
            q_sh_reg <= QW'(q2_reg);
        end
    end

    // recursion step with saturation to the state width
    assign x_ext    = SUM_W'(value) <<< FRAC_BITS;
    assign sum      = SUM_W'(prod_reg >>> COEF_FRAC) - SUM_W'(q2_reg) + x_ext;
    assign sum_top  = sum[SUM_W-1:STATE_BITS-1];
    assign sum_fits = (&sum_top) | ~(|sum_top);
    assign sum_sat  = sum_fits ? sum[STATE_BITS-1:0]
                    : (sum[SUM_W-1] ? {1'b1, {(STATE_BITS-1){1'b0}}}
                                    : {1'b0, {(STATE_BITS-1){1'b1}}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q1_reg  <= '0;
            q2_reg  <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.state_clr)
        begin
            q1_reg  <= '0;
            q2_reg  <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.update_en)
        begin
            q2_reg  <= q1_reg;
            q1_reg  <= sum_sat;
            ovf_reg <= ovf_reg | ~sum_fits;
        end
    end

    // drop fraction, clamp negative to zero
    assign m_u    = acc_reg[ACC_W-1] ? '0 : acc_reg[ACC_W-2:SQ_SH];
    assign m_ext  = EXT_W'(m_u);
    assign sq_sat = |m_ext[EXT_W-1:MAG_W];
    assign sq_mag = sq_sat ? '1 : m_ext[MAG_W-1:0];
    assign rad_in = (|m_ext[EXT_W-1:RAD_W]) ? '1 : m_ext[RAD_W-1:0];

    // digit-by-digit square root, one result bit per cycle
    assign rem_sh  = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial   = {2'b00, sq_root_reg, 2'b01};
    assign root_ge = (rem_sh >= trial);

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_init)
        begin
            rad_reg     <= rad_in;
            rem_reg     <= '0;
            sq_root_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            rad_reg     <= rad_reg << 2;
            rem_reg     <= root_ge ? rem_sh - trial : rem_sh;
            sq_root_reg <= {sq_root_reg[ROOT_W-2:0], root_ge};
        end
        if (cmd.out_load)
        begin
            mag_out_reg <= root_mode_reg ? sq_root_reg : sq_mag;
            sat_out_reg <= ovf_reg | (~root_mode_reg & sq_sat);
        end
    end

endmodule

// ===== rtl/core/goertzel_tone_detector_unit.sv =====
// goertzel tone detector top level
// sample item: accept, coefficient multiply, state update; clear item: cleared when accepted
// read item: multiply and accumulate per step on the state x 17-bit digit multiplier,
//   2 + ceil((STATE_BITS+16)/16) + ceil(STATE_BITS/16) steps, then a finish and an output state
// root mode adds the one-bit-per-cycle square root unit, one step per root bit
// reset clears the filter state, the overflow flag and all configuration registers
module goertzel_tone_detector_unit #(
    parameter int STATE_BITS = gtd_pkg::STATE_BITS_DEF,
    parameter int FRAC_BITS  = gtd_pkg::FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    gtd_in_if.sink     samples,
    gtd_out_if.source  results,
    gtd_cfg_if.sink    cfg
);
    import gtd_pkg::*;

    gtd_cmd_t    cmd;
    gtd_status_t status;

    assign cfg.ready = 1'b1;

    gtd_ctrl #(
        .STATE_BITS (STATE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_op     (samples.op),
        .in_ready  (samples.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .status    (status),
        .cmd       (cmd)
    );

    gtd_datapath #(
        .STATE_BITS (STATE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .sample    (samples.sample),
        .cfg_write (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .magnitude (results.magnitude),
        .saturated (results.saturated)
    );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// testbench for the goertzel tone detector: queue-fed driver, result monitor, bit-exact filter model
module testbench;
    import gtd_pkg::*;

    localparam int SB            = STATE_BITS_DEF;
    localparam int FB            = FRAC_BITS_DEF;
    localparam int WW            = 128;
    localparam int SETTLE_CYCLES = 120;
    localparam int HOLD_CYCLES   = 600;
    localparam int HOLD_MARK     = 150;
    localparam int RUN_LIMIT_NS  = 30_000_000;

    localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
    localparam logic [FMT_W-1:0]     FMT_ALT    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONE   = 2'd3;

    localparam logic signed [WW-1:0] STATE_HI = {{(WW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [WW-1:0] STATE_LO = ~STATE_HI;
    localparam logic signed [WW-1:0] MAG_HI   = {{(WW-MAG_W){1'b0}}, {MAG_W{1'b1}}};

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [SAMPLE_W-1:0] sample;
    } tone_item_t;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic             saturated;
    } tone_result_t;

    logic clk;
    logic rst_n;
    logic hold_off;

    gtd_in_if  samples_ch ();
    gtd_out_if results_ch ();
    gtd_cfg_if cfg_ch ();

    goertzel_tone_detector_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .results (results_ch),
        .cfg     (cfg_ch)
    );

    // filter model state and register copies
    logic signed [COEF_W-1:0] coef_reg;
    logic [FMT_W-1:0]         fmt_reg;
    logic                     root_reg;
    logic signed [SB-1:0]     q1;
    logic signed [SB-1:0]     q2;
    logic                     ovf_seen;

    tone_item_t   pending_items[$];
    tone_result_t expected_mags[$];
    int items_queued = 0;
    int items_taken  = 0;
    int errors       = 0;
    int send_idle    = 0;
    int send_calm    = 0;
    int recv_stall   = 0;
    int recv_calm    = 0;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int draw_gap(inout int calm_left);
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [WW-1:0] sample_level(input logic [SAMPLE_W-1:0] s);
        logic signed [WW-1:0] v;
        case (fmt_reg)
            FMT_U8:
            begin
                v = {{(WW-8){1'b0}}, s[7:0]};
                v = v - 128;
            end
            FMT_U16:
            begin
                v = {{(WW-SAMPLE_W){1'b0}}, s};
                v = v - 32768;
            end
            default: v = {{(WW-SAMPLE_W){s[SAMPLE_W-1]}}, s};
        endcase
        return v;
    endfunction

    function automatic logic [MAG_W-1:0] int_root(input logic signed [WW-1:0] v);
        logic [MAG_W-1:0] r;
        logic [MAG_W-1:0] t;
        logic [WW-1:0]    p;
        r = '0;
        for (int k = MAG_W - 1; k >= 0; k--)
        begin
            t = r | (MAG_W'(1) << k);
            p = WW'(t) * WW'(t);
            if (p <= $unsigned(v))
                r = t;
        end
        return r;
    endfunction

    task automatic filter_step(input logic [OP_W-1:0] op, input logic [SAMPLE_W-1:0] s);
        logic signed [WW-1:0] c;
        logic signed [WW-1:0] a;
        logic signed [WW-1:0] b;
        logic signed [WW-1:0] sum;
        logic signed [WW-1:0] m;
        tone_result_t res;
        c = {{(WW-COEF_W){coef_reg[COEF_W-1]}}, coef_reg};
        a = {{(WW-SB){q1[SB-1]}}, q1};
        b = {{(WW-SB){q2[SB-1]}}, q2};
        case (op)
            OP_SAMPLE:
            begin
                sum = ((c * a) >>> COEF_FRAC) - b + (sample_level(s) <<< FB);
                q2 = q1;
                if (sum > STATE_HI)
                begin
                    q1 = STATE_HI[SB-1:0];
                    ovf_seen = 1'b1;
                end
                else if (sum < STATE_LO)
                begin
                    q1 = STATE_LO[SB-1:0];
                    ovf_seen = 1'b1;
                end
                else
                    q1 = sum[SB-1:0];
            end
            OP_READ:
            begin
                m = (((a * a) + (b * b)) <<< COEF_FRAC) - (a * b * c);
                m = m >>> (2 * FB + COEF_FRAC);
                if (m < 0)
                    m = '0;
                res.saturated = ovf_seen;
                if (root_reg)
                    res.magnitude = int_root(m);
                else if (m > MAG_HI)
                begin
                    res.magnitude = '1;
                    res.saturated = 1'b1;
                end
                else
                    res.magnitude = m[MAG_W-1:0];
                expected_mags.push_back(res);
                q1 = '0;
                q2 = '0;
                ovf_seen = 1'b0;
            end
            OP_CLEAR:
            begin
                q1 = '0;
                q2 = '0;
                ovf_seen = 1'b0;
            end
            default: ;
        endcase
    endtask

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        tone_item_t cur;
        if (!rst_n)
        begin
            samples_ch.valid  <= 1'b0;
            samples_ch.op     <= '0;
            samples_ch.sample <= '0;
            send_idle = 0;
        end
        else
        begin
            if (samples_ch.valid && samples_ch.ready)
            begin
                filter_step(samples_ch.op, samples_ch.sample);
                items_taken++;
            end
            if (!samples_ch.valid || samples_ch.ready)
            begin
                if (send_idle > 0)
                begin
                    send_idle--;
                    samples_ch.valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    cur = pending_items.pop_front();
                    samples_ch.valid  <= 1'b1;
                    samples_ch.op     <= cur.op;
                    samples_ch.sample <= cur.sample;
                    send_idle = draw_gap(send_calm);
                end
                else
                    samples_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        tone_result_t want;
        logic took;
        if (!rst_n)
        begin
            results_ch.ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            took = results_ch.valid && results_ch.ready;
            if (took)
            begin
                if (expected_mags.size() == 0)
                begin
                    $display("%0t: result with no read waiting, actual magnitude %0d saturated %0b",
                             $time, results_ch.magnitude, results_ch.saturated);
                    errors++;
                end
                else
                begin
                    want = expected_mags.pop_front();
                    if (results_ch.magnitude !== want.magnitude)
                    begin
                        $display("%0t: magnitude mismatch, expected %0d actual %0d",
                                 $time, want.magnitude, results_ch.magnitude);
                        errors++;
                    end
                    if (results_ch.saturated !== want.saturated)
                    begin
                        $display("%0t: saturated mismatch, expected %0b actual %0b",
                                 $time, want.saturated, results_ch.saturated);
                        errors++;
                    end
                end
            end
            if (hold_off)
                results_ch.ready <= 1'b0;
            else if (recv_stall > 0)
            begin
                recv_stall--;
                results_ch.ready <= 1'b0;
            end
            else
            begin
                if (took || $urandom_range(0, 7) == 0)
                    recv_stall = draw_gap(recv_calm);
                results_ch.ready <= (recv_stall == 0);
            end
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial
    begin
        hold_off = 1'b0;
        wait (items_taken >= HOLD_MARK);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("timeout with %0d items queued, %0d taken, %0d results outstanding",
                 items_queued, items_taken, expected_mags.size());
        $display("Simulation FAILED");
        $finish;
    end

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_COEF:   coef_reg = value;
            REG_FORMAT: fmt_reg = value[FMT_W-1:0];
            REG_ROOT:   root_reg = value[0];
            default: ;
        endcase
    endtask

    task automatic add_item(input logic [OP_W-1:0] op, input logic [SAMPLE_W-1:0] s);
        tone_item_t it;
        it.op = op;
        it.sample = s;
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic drain();
        while (items_taken != items_queued || expected_mags.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] draw_sample();
        case ($urandom_range(0, 9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'hffff;
            3: return 16'h0000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    initial
    begin
        int run_len;
        int phase_start;
        logic [COEF_W-1:0] coef_pick;
        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        coef_reg = '0;
        fmt_reg = '0;
        root_reg = 1'b0;
        q1 = '0;
        q2 = '0;
        ovf_seen = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, empty read, unused op, clear
        set_reg(REG_COEF, 16'h7fff);
        set_reg(REG_FORMAT, CFG_DATA_W'(FMT_S16));
        set_reg(REG_ROOT, 16'h0000);
        add_item(OP_SAMPLE, 16'h7fff);
        add_item(OP_SAMPLE, 16'h8000);
        add_item(OP_SAMPLE, 16'h0000);
        add_item(OP_SAMPLE, 16'hffff);
        add_item(OP_READ, 16'hffff);
        add_item(OP_READ, 16'h0000);
        add_item(OP_SAMPLE, 16'h1234);
        add_item(OP_UNUSED, 16'hffff);
        add_item(OP_READ, 16'h0000);
        add_item(OP_SAMPLE, 16'h7fff);
        add_item(OP_CLEAR, 16'hffff);
        add_item(OP_READ, 16'h0000);
        drain();

        // most negative coefficient, 8-bit format with masked upper data bits, root mode
        set_reg(REG_COEF, 16'h8000);
        set_reg(REG_FORMAT, 16'hfffd);
        set_reg(REG_ROOT, 16'h0001);
        add_item(OP_SAMPLE, 16'h00ff);
        add_item(OP_SAMPLE, 16'hff00);
        add_item(OP_SAMPLE, 16'h0080);
        add_item(OP_SAMPLE, 16'h007f);
        add_item(OP_READ, 16'h0000);
        drain();

        // unused format code, write to an index with no register
        set_reg(REG_COEF, 16'h0000);
        set_reg(REG_FORMAT, CFG_DATA_W'(FMT_ALT));
        set_reg(REG_NONE, 16'hffff);
        set_reg(REG_ROOT, 16'hfffe);
        add_item(OP_SAMPLE, 16'hffff);
        add_item(OP_SAMPLE, 16'h8000);
        add_item(OP_READ, 16'h0000);
        drain();

        set_reg(REG_COEF, 16'h4000);
        set_reg(REG_FORMAT, CFG_DATA_W'(FMT_U16));
        add_item(OP_SAMPLE, 16'hffff);
        add_item(OP_SAMPLE, 16'h0000);
        add_item(OP_SAMPLE, 16'h8000);
        add_item(OP_READ, 16'h0000);
        drain();

        // random phases: sample runs closed by a read, mixed with noise
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: coef_pick = 16'h8000;
                1: coef_pick = 16'h7fff;
                default:
                    case ($urandom_range(0, 4))
                        0: coef_pick = 16'h8000;
                        1: coef_pick = 16'h7fff;
                        2: coef_pick = 16'h0000;
                        default: coef_pick = COEF_W'($urandom);
                    endcase
            endcase
            set_reg(REG_COEF, coef_pick);
            set_reg(REG_FORMAT, {14'($urandom), FMT_W'(ph % 4)});
            set_reg(REG_ROOT, {15'($urandom), 1'(ph % 2)});
            if ($urandom_range(0, 1) == 0)
                set_reg(REG_NONE, CFG_DATA_W'($urandom));
            phase_start = items_queued;
            while (items_queued - phase_start < 70)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                          : $urandom_range(1, 24);
                    if ($urandom_range(0, 5) == 0)
                        add_item(OP_CLEAR, SAMPLE_W'($urandom));
                    for (int k = 0; k < run_len; k++)
                        add_item(OP_SAMPLE, draw_sample());
                    if ($urandom_range(0, 5) == 0)
                        add_item(OP_UNUSED, SAMPLE_W'($urandom));
                    add_item(OP_READ, SAMPLE_W'($urandom));
                end
                else
                begin
                    case ($urandom_range(0, 2))
                        0: add_item(OP_CLEAR, SAMPLE_W'($urandom));
                        1: add_item(OP_UNUSED, SAMPLE_W'($urandom));
                        default: add_item(OP_READ, SAMPLE_W'($urandom));
                    endcase
                end
            end
            drain();
        end

        // resonance at half the sample rate: large root without state saturation
        set_reg(REG_COEF, 16'h8000);
        set_reg(REG_FORMAT, CFG_DATA_W'(FMT_S16));
        set_reg(REG_ROOT, 16'h0001);
        for (int k = 0; k < 360; k++)
            add_item(OP_SAMPLE, (k % 2 == 0) ? 16'h7fff : 16'h8000);
        drain();
        set_reg(REG_COEF, 16'h7fff);
        add_item(OP_READ, 16'h0000);
        drain();

        // longer resonance until the state saturates, then a saturating squared read
        set_reg(REG_COEF, 16'h8000);
        set_reg(REG_ROOT, 16'h0000);
        for (int k = 0; k < 760; k++)
            add_item(OP_SAMPLE, (k % 2 == 0) ? 16'h7fff : 16'h8000);
        drain();
        set_reg(REG_COEF, 16'h7fff);
        add_item(OP_READ, 16'h0000);
        drain();

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/gtd_pkg.sv
rtl/core/gtd_if.sv
rtl/core/gtd_ctrl.sv
rtl/core/gtd_datapath.sv
rtl/core/goertzel_tone_detector_unit.sv
sim/testbench.sv
